FILE: hw/rtl/scl_pkg.sv
// ----------------------------------------------------------------------------
// Serial command line parser package
// Character codes, sizes and the digit conversion stage type shared by the
// parser, its checker and the testbench.
// ----------------------------------------------------------------------------
package scl_pkg;

	// Argument buffer size including the terminator; an argument counts
	// FIELD_BUFFER_BYTES - 1 characters.
	localparam int FIELD_BUFFER_BYTES = 16;
	localparam int CHAR_LIMIT = FIELD_BUFFER_BYTES - 1;
	localparam int CHAR_CNT_W = $clog2(FIELD_BUFFER_BYTES);

	// Number of arguments after the command letter.
	localparam int NUM_ARGS = 3;

	// Character codes.
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_FF    = 8'd12;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_PLUS  = 8'd43;
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;

	// Saturation bounds in the widened accumulator.
	localparam int ACC_W = 36;
	localparam logic signed [ACC_W-1:0] VAL_MAX = 36'sh0_7FFF_FFFF;
	localparam logic signed [ACC_W-1:0] VAL_MIN = -36'sh0_8000_0000;

	// Field phase codes.
	localparam logic [1:0] PHASE_LETTER = 2'd0;
	localparam logic [1:0] PHASE_LAST   = 2'd3;

	// Digit conversion stage of the current argument.
	typedef enum logic [1:0] {
		CONV_WAIT   = 2'd0,
		CONV_DIGITS = 2'd1,
		CONV_DONE   = 2'd2
	} conv_stage_t;

endpackage

FILE: hw/rtl/serial_command_line_parser.sv
// ----------------------------------------------------------------------------
// Serial command line parser
// Splits a stream of received characters into a command letter and three
// integer arguments, and delivers one request per carriage return.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: rx_char with in_valid / in_stall. One character per
//   request; a character is taken at an edge where in_valid is high and
//   in_stall is low.
//   Output channel: command_letter, first_value, second_value, third_value
//   with out_valid / out_stall. One request leaves for every carriage
//   return; other characters only update the parser state.
//   Path: a carriage return passes the input register and then loads its
//   request into the output register, which drives the outputs.
//   Throughput: one character per cycle while in_stall is low. Each
//   character passes an input register and the combinational compare and
//   multiply-by-ten logic that updates the parser state and the output register.
//   Stall: the output register holds its request while out_stall is high.
//   Only a carriage return waiting behind a stalled result raises
//   in_stall; all other characters keep flowing.
//   Reset: arst_n clears the parser state and both valid flags at once;
//   the block takes characters as soon as reset is released.
// ----------------------------------------------------------------------------
module serial_command_line_parser
	import scl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  command_letter,
	output logic signed [31:0] first_value,
	output logic signed [31:0] second_value,
	output logic signed [31:0] third_value
);

	// Input register.
	logic       valid_s1;
	logic [7:0] char_s1;

	// Parser state.
	logic [1:0]            phase_q;
	logic [CHAR_CNT_W-1:0] char_cnt_q;
	logic [7:0]            letter_q;
	logic signed [31:0]    field_val_q [NUM_ARGS];
	conv_stage_t           conv_q;
	logic                  neg_q;

	// Output register.
	logic                  out_valid_q;
	logic [7:0]            out_letter_q;
	logic signed [31:0]    out_val_q [NUM_ARGS];

	// Next state.
	logic [1:0]            phase_d;
	logic [CHAR_CNT_W-1:0] char_cnt_d;
	logic [7:0]            letter_d;
	logic signed [31:0]    field_val_d [NUM_ARGS];
	conv_stage_t           conv_d;
	logic                  neg_d;

	logic                  is_cr;
	logic                  is_digit;
	logic                  advance;
	logic [1:0]            slot;
	logic signed [ACC_W-1:0] cur_ext;
	logic signed [ACC_W-1:0] times_ten;
	logic signed [ACC_W-1:0] digit_ext;
	logic signed [ACC_W-1:0] acc;
	logic signed [31:0]    acc_sat;

	// The character in the input register moves on unless it is a carriage
	// return and the output register holds a stalled request.
	assign is_cr    = (char_s1 == CHAR_CR);
	assign is_digit = (char_s1 inside {[CHAR_ZERO:CHAR_NINE]});
	assign advance  = valid_s1 && !(is_cr && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			char_s1 <= rx_char;
		end
	end

	// Multiply the running value by ten and add or subtract the digit,
	// then clamp to the 32-bit signed range.
	assign slot      = phase_q - 2'd1;
	assign cur_ext   = ACC_W'(field_val_q[slot]);
	assign times_ten = (cur_ext <<< 3) + (cur_ext <<< 1);
	assign digit_ext = {{(ACC_W-4){1'b0}}, char_s1[3:0]};
	assign acc       = neg_q ? (times_ten - digit_ext) : (times_ten + digit_ext);

	always_comb begin
		if (acc > VAL_MAX) begin
			acc_sat = VAL_MAX[31:0];
		end else if (acc < VAL_MIN) begin
			acc_sat = VAL_MIN[31:0];
		end else begin
			acc_sat = acc[31:0];
		end
	end

	// Next parser state for the character in the input register.
	always_comb begin
		phase_d     = phase_q;
		char_cnt_d  = char_cnt_q;
		letter_d    = letter_q;
		field_val_d = field_val_q;
		conv_d      = conv_q;
		neg_d       = neg_q;
		if (is_cr) begin
			// End of line: everything returns to its reset value.
			phase_d     = PHASE_LETTER;
			char_cnt_d  = '0;
			letter_d    = '0;
			field_val_d = '{default: '0};
			conv_d      = CONV_WAIT;
			neg_d       = 1'b0;
		end else if (char_s1 == CHAR_SPACE) begin
			// A space starts the next argument; after the third it is ignored.
			if (phase_q != PHASE_LAST) begin
				phase_d    = phase_q + 2'd1;
				char_cnt_d = '0;
				conv_d     = CONV_WAIT;
				neg_d      = 1'b0;
			end
		end else if (phase_q == PHASE_LETTER) begin
			letter_d = char_s1;
		end else if (char_cnt_q < CHAR_CNT_W'(CHAR_LIMIT)) begin
			char_cnt_d = char_cnt_q + CHAR_CNT_W'(1);
			case (conv_q)
				CONV_WAIT: begin
					if (char_s1 inside {[CHAR_TAB:CHAR_FF]}) begin
						conv_d = CONV_WAIT;
					end else if (char_s1 == CHAR_PLUS || char_s1 == CHAR_MINUS) begin
						neg_d  = (char_s1 == CHAR_MINUS);
						conv_d = CONV_DIGITS;
					end else if (is_digit) begin
						conv_d            = CONV_DIGITS;
						field_val_d[slot] = acc_sat;
					end else begin
						conv_d = CONV_DONE;
					end
				end
				CONV_DIGITS: begin
					if (is_digit) begin
						field_val_d[slot] = acc_sat;
					end else begin
						conv_d = CONV_DONE;
					end
				end
				default: begin
					conv_d = conv_q;
				end
			endcase
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PHASE_LETTER;
			char_cnt_q  <= '0;
			letter_q    <= '0;
			field_val_q <= '{default: '0};
			conv_q      <= CONV_WAIT;
			neg_q       <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			char_cnt_q  <= char_cnt_d;
			letter_q    <= letter_d;
			field_val_q <= field_val_d;
			conv_q      <= conv_d;
			neg_q       <= neg_d;
		end
	end

	// Output register: loaded by a carriage return, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_cr) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_cr) begin
			out_letter_q <= letter_q;
			out_val_q    <= field_val_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign command_letter = out_letter_q;
	assign first_value    = out_val_q[0];
	assign second_value   = out_val_q[1];
	assign third_value    = out_val_q[2];

endmodule

FILE: hw/rtl/scl_checker.sv
// ----------------------------------------------------------------------------
// Serial command line parser checker
// Port-level assertions on the parser's handshakes and request timing.
// ----------------------------------------------------------------------------
module scl_checker
	import scl_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  rx_char,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  command_letter,
	input logic [31:0] first_value,
	input logic [31:0] second_value,
	input logic [31:0] third_value
);

	// A stalled request stays valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output request dropped while stalled");

	// A stalled request keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(command_letter) && $stable(first_value)
			&& $stable(second_value) && $stable(third_value))
		else $error("output payload changed while stalled");

	// The input side waits only behind a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// Each new result must trace back to a carriage return that was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && rx_char == CHAR_CR, 2))
		else $error("result without a carriage return two cycles earlier");

endmodule

bind serial_command_line_parser scl_checker u_scl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.rx_char        (rx_char),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.command_letter (command_letter),
	.first_value    (first_value),
	.second_value   (second_value),
	.third_value    (third_value)
);

FILE: tb/serial_command_line_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command line parser testbench
// Streams directed and random command lines into the parser, predicts the
// command letter and the three converted arguments of every carriage return,
// and compares each result request against that prediction in order. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module serial_command_line_parser_tb;
	import scl_pkg::*;

	// One predicted command result.
	typedef struct packed {
		logic [7:0]  letter;
		logic [31:0] arg1;
		logic [31:0] arg2;
		logic [31:0] arg3;
	} command_result_t;

	// Tracks the parser state and holds the commands still to come out.
	class command_scoreboard;
		logic [1:0]                 phase;
		logic [4:0]                 char_count;
		logic [7:0]                 letter;
		logic signed [ACC_W-1:0]    arg_acc [NUM_ARGS];
		conv_stage_t                stage;
		logic                       negative;
		command_result_t            pending_commands [$];
		int                         errors;
		int                         chars_parsed;
		int                         commands_checked;

		function new();
			errors = 0;
			chars_parsed = 0;
			commands_checked = 0;
			clear_line();
		endfunction

		function void clear_line();
			phase = PHASE_LETTER;
			char_count = '0;
			letter = '0;
			foreach (arg_acc[i])
				arg_acc[i] = '0;
			stage = CONV_WAIT;
			negative = 1'b0;
		endfunction

		function int pending();
			return pending_commands.size();
		endfunction

		task report_mismatch(input string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		// Advance the parser state by one accepted character.
		function void parse_char(input logic [7:0] c);
			command_result_t         res;
			logic signed [ACC_W-1:0] digit;
			logic signed [ACC_W-1:0] acc;
			logic                    take;
			int                      slot;

			chars_parsed++;
			take = 1'b0;
			digit = $signed({{(ACC_W-8){1'b0}}, c - CHAR_ZERO});
			if (c == CHAR_CR) begin
				res.letter = letter;
				res.arg1 = arg_acc[0][31:0];
				res.arg2 = arg_acc[1][31:0];
				res.arg3 = arg_acc[2][31:0];
				pending_commands.push_back(res);
				clear_line();
			end else if (c == CHAR_SPACE) begin
				// Spaces past the third argument change nothing.
				if (phase < PHASE_LAST) begin
					phase++;
					char_count = '0;
					stage = CONV_WAIT;
					negative = 1'b0;
				end
			end else if (phase == PHASE_LETTER) begin
				letter = c;
			end else if (char_count < CHAR_LIMIT) begin
				slot = phase - 1;
				char_count++;
				case (stage)
					CONV_WAIT: begin
						if (c >= CHAR_TAB && c <= CHAR_FF) begin
							// Leading whitespace is skipped.
						end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
							negative = (c == CHAR_MINUS);
							stage = CONV_DIGITS;
						end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
							stage = CONV_DIGITS;
							take = 1'b1;
						end else begin
							stage = CONV_DONE;
						end
					end
					CONV_DIGITS: begin
						if (c >= CHAR_ZERO && c <= CHAR_NINE)
							take = 1'b1;
						else
							stage = CONV_DONE;
					end
					default: begin
					end
				endcase
				// Multiply by ten, add the digit with the sign, and saturate.
				if (take) begin
					acc = arg_acc[slot] * $signed(36'sd10);
					if (negative) begin
						acc = acc - digit;
						if (acc < VAL_MIN)
							acc = VAL_MIN;
					end else begin
						acc = acc + digit;
						if (acc > VAL_MAX)
							acc = VAL_MAX;
					end
					arg_acc[slot] = acc;
				end
			end
		endfunction

		// Compare one result request with the oldest prediction.
		task check_command(input logic [7:0] got_letter, input logic [31:0] got1,
				input logic [31:0] got2, input logic [31:0] got3);
			command_result_t want;

			if (pending_commands.size() == 0) begin
				report_mismatch($sformatf("result with nothing predicted, letter %0d",
					got_letter));
			end else begin
				want = pending_commands.pop_front();
				commands_checked++;
				if (got_letter !== want.letter)
					report_mismatch($sformatf("command_letter got %0d want %0d",
						got_letter, want.letter));
				if (got1 !== want.arg1)
					report_mismatch($sformatf("first_value got %0d want %0d",
						$signed(got1), $signed(want.arg1)));
				if (got2 !== want.arg2)
					report_mismatch($sformatf("second_value got %0d want %0d",
						$signed(got2), $signed(want.arg2)));
				if (got3 !== want.arg3)
					report_mismatch($sformatf("third_value got %0d want %0d",
						$signed(got3), $signed(want.arg3)));
			end
		endtask
	endclass

	localparam int RANDOM_CHARS = 1750;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         rx_char;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         command_letter;
	logic signed [31:0] first_value;
	logic signed [31:0] second_value;
	logic signed [31:0] third_value;

	command_scoreboard  sb;
	logic               no_gaps;
	int                 chars_sent;

	serial_command_line_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_char        (rx_char),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.command_letter (command_letter),
		.first_value    (first_value),
		.second_value   (second_value),
		.third_value    (third_value)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly no pause, often a short one, now and then a long one.
	function automatic int random_pause(input int longest);
		int r;

		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, longest);
	endfunction

	// Offer one character and hold it until the parser takes the request.
	task automatic send_char(input logic [7:0] c);
		int pause;

		pause = no_gaps ? 0 : random_pause(40);
		if (pause > 0) begin
			in_valid <= 1'b0;
			rx_char <= 8'($urandom_range(0, 255));
			repeat (pause) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_char <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// Stop sending and let every predicted result come out.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Accepted input requests feed the predictor.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.parse_char(rx_char);
	end

	// Accepted result requests are checked against the prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_command(command_letter, first_value, second_value, third_value);
	end

	// Receiver stalls: short and long ones, with some long stall-free stretches.
	initial begin
		int stall_len;
		int free_len;

		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			stall_len = random_pause(60);
			free_len = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 300)
				: $urandom_range(0, 8);
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat (free_len) @(posedge clk);
		end
	end

	// Main stimulus.
	initial begin
		logic [7:0] line_q [$];
		logic [7:0] ch;
		string      edge_values [4];
		string      ev;
		int         n;
		int         nargs;
		int         r;
		bit         drained_mid;

		edge_values = '{"2147483647", "2147483648", "-2147483648", "-2147483649"};
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_char = '0;
		no_gaps = 1'b0;
		chars_sent = 0;
		drained_mid = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Empty line: all fields stay zero.
		send_char(CHAR_CR);
		// Last letter wins, negative saturation, a sign alone, and characters
		// after a space past the third argument still extend that argument.
		send_char("m");
		send_char(8'hFF);
		send_text(" -99999999999 + 4 7");
		send_char(CHAR_CR);
		// Zero byte as letter, leading whitespace, an over-long argument and
		// positive saturation.
		send_char(8'h00);
		send_char(CHAR_SPACE);
		send_char(CHAR_TAB);
		send_char(CHAR_TAB + 8'd1);
		send_char(CHAR_TAB + 8'd2);
		send_char(CHAR_FF);
		send_text("000000000042999 +99999999999");
		send_char(CHAR_CR);
		// A zero byte and a letter end their arguments.
		send_text("Z 5");
		send_char(8'h00);
		send_text("6 x7");
		send_char(CHAR_CR);
		wait_for_results();

		// Random part: mostly well-formed lines with random content, some noise.
		while (chars_sent < RANDOM_CHARS) begin
			line_q.delete();
			no_gaps = ($urandom_range(0, 6) == 0);
			if ($urandom_range(0, 99) < 15) begin
				n = $urandom_range(1, 20);
				repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
				repeat (n) begin
					do
						ch = 8'($urandom_range(0, 255));
					while (ch == CHAR_CR || ch == CHAR_SPACE);
					line_q.push_back(ch);
				end
				// A count of four puts spaces past the third argument.
				nargs = $urandom_range(0, 4);
				for (int a = 0; a < nargs; a++) begin
					line_q.push_back(CHAR_SPACE);
					if ($urandom_range(0, 4) == 0)
						repeat ($urandom_range(1, 3))
							line_q.push_back(CHAR_TAB + 8'($urandom_range(0, 3)));
					if ($urandom_range(0, 19) == 0) begin
						ev = edge_values[$urandom_range(0, 3)];
						for (int k = 0; k < ev.len(); k++)
							line_q.push_back(ev[k]);
					end else begin
						r = $urandom_range(0, 3);
						if (r == 0)
							line_q.push_back(CHAR_PLUS);
						else if (r == 1)
							line_q.push_back(CHAR_MINUS);
						r = $urandom_range(0, 19);
						n = (r == 0) ? 0 : (r < 15) ? $urandom_range(1, 6)
							: (r < 18) ? $urandom_range(8, 12) : $urandom_range(13, 20);
						repeat (n) line_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
					end
					if ($urandom_range(0, 4) == 0) begin
						do
							ch = 8'($urandom_range(0, 255));
						while (ch == CHAR_CR);
						line_q.push_back(ch);
					end
				end
				// Now and then a line runs on into the next without a return.
				if ($urandom_range(0, 9) != 0)
					line_q.push_back(CHAR_CR);
			end
			foreach (line_q[i])
				send_char(line_q[i]);
			// Let the parser drain once in the middle of the run.
			if (!drained_mid && chars_sent > RANDOM_CHARS / 2) begin
				drained_mid = 1'b1;
				wait_for_results();
			end
		end
		no_gaps = 1'b0;
		send_char(CHAR_CR);

		// Drain and let anything stray arrive before the final check.
		wait_for_results();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d predicted results never arrived",
				sb.pending()));
		$display("Parsed %0d characters (directed lines, random commands and noise),",
			sb.chars_parsed);
		$display("checked %0d command results with random gaps and stalls.",
			sb.commands_checked);
		if (sb.errors == 0)
			$display("serial_command_line_parser_tb: clean");
		else
			$display("serial_command_line_parser_tb: errors");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20_000_000;
		$display("serial_command_line_parser_tb: errors");
		$finish;
	end

endmodule
